>>> src/mlr_pkg.sv
// Shared types, codes and sizes for the multichannel linear ramp unit.
// Used by mlr_cell, mlr_div and multichannel_linear_ramp_unit; depends on nothing.
`default_nettype none

package mlr_pkg;

    localparam int CHANNELS = 8;
    localparam int NCH = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 16;
    localparam int CHAN_W = 3;
    localparam int DIV_W = VALUE_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_ADVANCE = 2'd1,
        KIND_FINISH  = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] cur;
        logic [VALUE_W-1:0] step;
        logic [VALUE_W-1:0] tgt;
    } cell_t;

    function automatic logic [VALUE_W-1:0] sat_add(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
        logic [VALUE_W:0] sum;
        begin
            sum = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
            if (sum[VALUE_W] != sum[VALUE_W-1])
            begin
                sat_add = sum[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                       : {1'b0, {(VALUE_W-1){1'b1}}};
            end
            else
            begin
                sat_add = sum[VALUE_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

>>> src/multichannel_linear_ramp_unit.sv
// Top level of the multichannel linear ramp unit: request control, output register
// and the ring of channel cells. Depends on mlr_pkg, mlr_cell and mlr_div.
//
// Channel    Direction  Signals                        Contents (low bit first)
// request    in         s_axis_tvalid/tready/tdata/tuser  tuser: kind; tdata: channel,
//                                                       start_value, target_value
// result     out        m_axis_tvalid/tready/tdata/tlast  tdata: out_channel, out_value;
//                                                       tlast: last
// config     in         cfg_wr_en, cfg_wr_data          step_count
//
// A load request is worked out by the one-bit-per-cycle step divider.
// An advance or finish request rotates the cell ring once, one channel per cycle
// while the result side does not stall; a clear drops every valid bit and stays idle.
// A stalled result holds the ring in place; the next request is taken once the
// ring is back at rest. Reset clears every valid bit and sets step_count to one.
`default_nettype none

module multichannel_linear_ramp_unit (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // channel [2:0], start_value [34:3], target_value [66:35], zero fill above
    input  wire [mlr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // kind [1:0]
    input  wire [1:0]                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // out_channel [2:0], out_value [34:3], zero fill above
    output logic [mlr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast,
    input  wire                                cfg_wr_en,
    input  wire [mlr_pkg::COUNT_W-1:0]         cfg_wr_data
);

    localparam int NCH = mlr_pkg::NCH;
    localparam int VW = mlr_pkg::VALUE_W;
    localparam int IW = mlr_pkg::IDX_W;
    localparam int CHW = mlr_pkg::CHAN_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV   = 3'b010,
        ST_SWEEP = 3'b100
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    mlr_pkg::kind_t              kind_reg;
    logic [IW-1:0]               idx_reg;
    logic [mlr_pkg::COUNT_W-1:0] step_count_reg;
    logic [CHW-1:0]              chan_reg;
    logic [VW-1:0]               start_reg;
    logic [VW-1:0]               tgt_reg;

    logic                        out_valid_reg;
    logic [CHW-1:0]              out_chan_reg;
    logic [VW-1:0]               out_value_reg;
    logic                        out_last_reg;

    mlr_pkg::cell_t              cell_q [NCH];
    mlr_pkg::cell_t              head_new;
    mlr_pkg::cell_t              load_rec;

    logic                        accept;
    mlr_pkg::kind_t              in_kind;
    logic [CHW-1:0]              in_chan;
    logic [VW-1:0]               in_start;
    logic [VW-1:0]               in_tgt;
    logic [VW:0]                 diff;
    logic [mlr_pkg::DIV_W-1:0]   diff_mag;
    logic                        div_start;
    logic                        div_done;
    logic [VW-1:0]               div_q;
    logic                        slot_free;
    logic                        shift_en;
    logic                        clear_all;
    logic                        later_valid;

    assign in_kind  = mlr_pkg::kind_t'(s_axis_tuser);
    assign in_chan  = s_axis_tdata[CHW-1:0];
    assign in_start = s_axis_tdata[CHW+VW-1:CHW];
    assign in_tgt   = s_axis_tdata[CHW+2*VW-1:CHW+VW];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign diff      = {in_tgt[VW-1], in_tgt} - {in_start[VW-1], in_start};
    assign diff_mag  = diff[VW] ? (~diff + 1'b1) : diff;
    assign div_start = accept && (in_kind == mlr_pkg::KIND_LOAD);
    assign clear_all = accept && (in_kind == mlr_pkg::KIND_CLEAR);

    mlr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .magnitude (diff_mag),
        .negative  (diff[VW]),
        .divisor   (step_count_reg),
        .done      (div_done),
        .quotient  (div_q)
    );

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign shift_en  = (state_reg == ST_SWEEP) && slot_free;

    always_comb
    begin
        head_new = cell_q[0];
        if (cell_q[0].valid)
        begin
            if (kind_reg == mlr_pkg::KIND_ADVANCE)
            begin
                head_new.cur = mlr_pkg::sat_add(cell_q[0].cur, cell_q[0].step);
            end
            else
            begin
                head_new.cur = cell_q[0].tgt;
            end
        end
    end

    always_comb
    begin
        later_valid = 1'b0;
        for (int p = 1; p < NCH; p++)
        begin
            if (cell_q[p].valid && (p < NCH - int'(idx_reg)))
            begin
                later_valid = 1'b1;
            end
        end
    end

    assign load_rec = '{valid: 1'b1, cur: start_reg, step: div_q, tgt: tgt_reg};

    for (genvar k = 0; k < NCH; k++)
    begin : g_cell
        mlr_pkg::cell_t shift_src;
        if (k == NCH - 1)
        begin : g_tail
            assign shift_src = head_new;
        end
        else
        begin : g_body
            assign shift_src = cell_q[k+1];
        end

        mlr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .shift_in (shift_src),
            .load_en  (div_done && (chan_reg == CHW'(k))),
            .load_in  (load_rec),
            .clear    (clear_all),
            .state    (cell_q[k])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == mlr_pkg::KIND_LOAD)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (in_kind != mlr_pkg::KIND_CLEAR)
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (shift_en && (idx_reg == IW'(NCH - 1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_count_reg <= mlr_pkg::COUNT_W'(1);
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                step_count_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                idx_reg <= '0;
            end
            else if (shift_en)
            begin
                idx_reg <= (idx_reg == IW'(NCH - 1)) ? '0 : idx_reg + 1'b1;
            end
            if (shift_en && cell_q[0].valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= in_kind;
            chan_reg  <= in_chan;
            start_reg <= in_start;
            tgt_reg   <= in_tgt;
        end
        if (shift_en && cell_q[0].valid)
        begin
            out_chan_reg  <= CHW'(idx_reg);
            out_value_reg <= head_new.cur;
            out_last_reg  <= !later_valid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(mlr_pkg::OUT_DATA_W - VW - CHW){1'b0}}, out_value_reg, out_chan_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> src/mlr_cell.sv
// One channel cell of the ramp chain: holds value, step, target and valid bit.
// Depends on mlr_pkg for the cell record type.
`default_nettype none

module mlr_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  shift_en,
    input  wire mlr_pkg::cell_t  shift_in,
    input  wire                  load_en,
    input  wire mlr_pkg::cell_t  load_in,
    input  wire                  clear,
    output mlr_pkg::cell_t       state
);

    logic                        valid_reg;
    logic [mlr_pkg::VALUE_W-1:0] cur_reg;
    logic [mlr_pkg::VALUE_W-1:0] step_reg;
    logic [mlr_pkg::VALUE_W-1:0] tgt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_en)
        begin
            valid_reg <= load_in.valid;
        end
        else if (shift_en)
        begin
            valid_reg <= shift_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            cur_reg  <= load_in.cur;
            step_reg <= load_in.step;
            tgt_reg  <= load_in.tgt;
        end
        else if (shift_en)
        begin
            cur_reg  <= shift_in.cur;
            step_reg <= shift_in.step;
            tgt_reg  <= shift_in.tgt;
        end
    end

    assign state = '{valid: valid_reg, cur: cur_reg, step: step_reg, tgt: tgt_reg};

endmodule

`default_nettype wire

>>> src/mlr_div.sv
// Restoring divider for the ramp step: one quotient bit per cycle, signed result
// truncated toward zero and saturated to 32 bits. Depends on mlr_pkg for widths.
`default_nettype none

module mlr_div (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [mlr_pkg::DIV_W-1:0]     magnitude,
    input  wire                          negative,
    input  wire [mlr_pkg::COUNT_W-1:0]   divisor,
    output logic                         done,
    output logic [mlr_pkg::VALUE_W-1:0]  quotient
);

    localparam int DW = mlr_pkg::DIV_W;
    localparam int CW = mlr_pkg::COUNT_W;
    localparam int VW = mlr_pkg::VALUE_W;

    logic                         busy_reg;
    logic                         done_reg;
    logic [mlr_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [DW-1:0]                quo_reg;
    logic [CW:0]                  rem_reg;
    logic [CW-1:0]                den_reg;
    logic                         neg_reg;

    logic [CW:0]   trial;
    logic          fits;
    logic [CW:0]   rem_next;
    logic [DW-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_reg[CW-1:0], quo_reg[DW-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? (trial - {1'b0, den_reg}) : trial;
        quo_next = {quo_reg[DW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == mlr_pkg::DIV_CNT_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= magnitude;
            rem_reg <= '0;
            den_reg <= (divisor == '0) ? CW'(1) : divisor;
            neg_reg <= negative;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        if (!neg_reg && (quo_reg > DW'({1'b0, {(VW-1){1'b1}}})))
        begin
            quotient = {1'b0, {(VW-1){1'b1}}};
        end
        else if (neg_reg && (quo_reg > DW'({1'b1, {(VW-1){1'b0}}})))
        begin
            quotient = {1'b1, {(VW-1){1'b0}}};
        end
        else if (neg_reg)
        begin
            quotient = VW'(~quo_reg + 1'b1);
        end
        else
        begin
            quotient = quo_reg[VW-1:0];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire
